[rtl/union_find_engine_assert.svh]
// Assertion macros shared by the union-find engine modules.
// The asserting module must have i_clk and i_rst_n ports.
`ifndef UNION_FIND_ENGINE_ASSERT_SVH
`define UNION_FIND_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UFE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ufe_pkg.sv]
package ufe_pkg;

    localparam int NODES_DEF = 1024;
    localparam int NW        = 10;
    localparam int RANK_W    = 4;
    localparam int SIZE_W    = 11;

    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd2047;

    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_UNION  = 1'b1;
    localparam logic MODE_RANK = 1'b0;
    localparam logic MODE_SIZE = 1'b1;
    localparam logic SIDE_A    = 1'b0;
    localparam logic SIDE_B    = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_W_ISSUE,
        S_W_WALK,
        S_C_ISSUE,
        S_C_WALK,
        S_L_RD_A,
        S_L_RD_B,
        S_L_DO,
        S_RESP
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic walk_issue;
        logic walk_step;
        logic walk_root;
        logic comp_issue;
        logic comp_step;
        logic comp_done;
        logic link_rd_a;
        logic link_rd_b;
        logic link;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_ok;
        logic op;
        logic side;
        logic at_root;
        logic cur_is_root;
        logic comp_end;
        logic roots_eq;
        logic clr_last;
    } t_dp_sts;

endpackage

[rtl/union_find_engine.sv]
// Find walks node_a's parent path to its root, then points every node on that path at the root.
// Union does this for node_a and then node_b, and links the two roots when they differ.
// One item at a time; the next transfer is taken in the cycle after the result is loaded, later
// if a stalled result still holds the output register. Rate set by the parent table walks.
// Out-of-range items go straight to the result state, with no table access.
// Reset (sync, active low) starts a clearing pass over every table entry; no input is taken until done.
module union_find_engine
    import ufe_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_op,
    input  logic [NW-1:0] i_node_a,
    input  logic [NW-1:0] i_node_b,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [NW-1:0] o_root,
    output logic          o_merged
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ufe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ufe_dp #(.NODES(NODES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_op          (i_op),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .o_root        (o_root),
        .o_merged      (o_merged),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

[rtl/ufe_ram.sv]
module ufe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ufe_ctrl.sv]
`include "union_find_engine_assert.svh"

module ufe_ctrl
    import ufe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = i_sts.in_ok ? S_W_ISSUE : S_RESP;
            end
            S_W_ISSUE: n_state = S_W_WALK;
            S_W_WALK: begin
                if (i_sts.at_root) n_state = S_C_ISSUE;
            end
            S_C_ISSUE: begin
                if (!i_sts.cur_is_root) begin
                    n_state = S_C_WALK;
                end else if (i_sts.side == SIDE_A) begin
                    n_state = (i_sts.op == OP_UNION) ? S_W_ISSUE : S_RESP;
                end else begin
                    n_state = i_sts.roots_eq ? S_RESP : S_L_RD_A;
                end
            end
            S_C_WALK: begin
                if (i_sts.comp_end) n_state = S_C_ISSUE;
            end
            S_L_RD_A: n_state = S_L_RD_B;
            S_L_RD_B: n_state = S_L_DO;
            S_L_DO:   n_state = S_RESP;
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        n_out_valid = i_stall ? r_out_valid : 1'b0;
        case (r_state)
            S_CLEAR:   o_cmd.clr_step   = 1'b1;
            S_IDLE:    o_cmd.load_in    = i_valid;
            S_W_ISSUE: o_cmd.walk_issue = 1'b1;
            S_W_WALK: begin
                o_cmd.walk_root = i_sts.at_root;
                o_cmd.walk_step = !i_sts.at_root;
            end
            S_C_ISSUE: begin
                o_cmd.comp_issue = !i_sts.cur_is_root;
                o_cmd.comp_done  = i_sts.cur_is_root;
            end
            S_C_WALK:  o_cmd.comp_step = 1'b1;
            S_L_RD_A:  o_cmd.link_rd_a = 1'b1;
            S_L_RD_B:  o_cmd.link_rd_b = 1'b1;
            S_L_DO:    o_cmd.link      = 1'b1;
            S_RESP: begin
                o_cmd.out_load = out_free;
                if (out_free) n_out_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    `UFE_ASSERT_NXT(a_accept_busy, i_valid && !o_stall, o_stall, "input taken while busy")
    `UFE_ASSERT_IMP(a_clear_no_out, r_state == S_CLEAR, !r_out_valid, "result during clear")
    `UFE_ASSERT_NXT(a_link_resp, r_state == S_L_DO, r_state == S_RESP, "link not followed by result")

endmodule

[rtl/ufe_dp.sv]
`include "union_find_engine_assert.svh"

module ufe_dp
    import ufe_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_op,
    input  logic [NW-1:0] i_node_a,
    input  logic [NW-1:0] i_node_b,
    output logic [NW-1:0] o_root,
    output logic          o_merged,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts
);

    localparam int AW = $clog2(NODES);
    localparam int XW = (AW > NW) ? AW : NW;
    localparam logic [16:0] NODES_V = 17'(NODES);

    logic              r_mode;
    logic [AW-1:0]     r_clr;
    logic              r_op, r_bad, r_side, r_merged;
    logic [NW-1:0]     r_a, r_b;
    logic [AW-1:0]     r_cur, r_start, r_root, r_root_a, r_win;
    logic [RANK_W-1:0] r_ka;
    logic [SIZE_W-1:0] r_sa;
    logic [NW-1:0]     r_out_root;
    logic              r_out_merged;

    logic [XW-1:0]     a_x, b_x, win_x, root_x;
    logic [AW-1:0]     a_addr, b_addr;
    logic              a_ok, b_ok;

    logic [AW-1:0]     p_raddr, p_waddr, p_wdata, p_rdata;
    logic              p_we;
    logic [AW-1:0]     k_addr, k_waddr, s_waddr;
    logic [RANK_W-1:0] k_wdata, k_rdata;
    logic [SIZE_W-1:0] s_wdata, s_rdata;
    logic              k_we, s_we;

    logic              a_wins;
    logic [AW-1:0]     winner, loser;
    logic [SIZE_W:0]   size_sum;
    logic [SIZE_W-1:0] size_sat;

    assign a_x    = XW'(i_node_a);
    assign b_x    = XW'(r_b);
    assign a_addr = a_x[AW-1:0];
    assign b_addr = b_x[AW-1:0];
    assign a_ok   = (17'(i_node_a) < NODES_V);
    assign b_ok   = (17'(i_node_b) < NODES_V);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RANK;
            r_clr  <= '0;
        end else begin
            if (i_cfg_wr_en) r_mode <= i_cfg_wr_data;
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
        end
    end

    // linking decision
    always_comb begin
        if (r_mode == MODE_RANK) begin
            a_wins = (r_ka >= k_rdata);
        end else begin
            a_wins = (r_sa > s_rdata);
        end
        winner   = a_wins ? r_root_a : r_root;
        loser    = a_wins ? r_root : r_root_a;
        size_sum = {1'b0, r_sa} + {1'b0, s_rdata};
        size_sat = (size_sum > {1'b0, SIZE_MAX}) ? SIZE_MAX : size_sum[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_op;
            r_a      <= i_node_a;
            r_b      <= i_node_b;
            r_bad    <= !(a_ok && (i_op == OP_FIND || b_ok));
            r_side   <= SIDE_A;
            r_cur    <= a_addr;
            r_start  <= a_addr;
            r_merged <= 1'b0;
        end
        if (i_cmd.walk_step) r_cur <= p_rdata;
        if (i_cmd.walk_root) begin
            r_root <= r_cur;
            r_cur  <= r_start;
        end
        if (i_cmd.comp_step) r_cur <= p_rdata;
        if (i_cmd.comp_done && r_side == SIDE_A) begin
            r_root_a <= r_root;
            r_side   <= SIDE_B;
            r_cur    <= b_addr;
            r_start  <= b_addr;
        end
        if (i_cmd.link_rd_b) begin
            r_ka <= k_rdata;
            r_sa <= s_rdata;
        end
        if (i_cmd.link) begin
            r_win    <= winner;
            r_merged <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_merged <= r_merged;
            if (r_bad) begin
                r_out_root <= r_a;
            end else begin
                r_out_root <= r_merged ? win_x[NW-1:0] : root_x[NW-1:0];
            end
        end
    end

    assign win_x  = XW'(r_win);
    assign root_x = XW'(r_root);

    // parent table port control
    always_comb begin
        p_raddr = (i_cmd.walk_step || i_cmd.comp_step) ? p_rdata : r_cur;
        p_we    = 1'b0;
        p_waddr = r_cur;
        p_wdata = r_root;
        if (i_cmd.clr_step) begin
            p_we    = 1'b1;
            p_waddr = r_clr;
            p_wdata = r_clr;
        end else if (i_cmd.comp_step) begin
            p_we    = 1'b1;
        end else if (i_cmd.link) begin
            p_we    = 1'b1;
            p_waddr = loser;
            p_wdata = winner;
        end
    end

    // rank and size table port control
    always_comb begin
        k_addr  = i_cmd.link_rd_b ? r_root : r_root_a;
        k_we    = 1'b0;
        k_waddr = r_root_a;
        k_wdata = r_ka + 1'b1;
        s_we    = 1'b0;
        s_waddr = winner;
        s_wdata = size_sat;
        if (i_cmd.clr_step) begin
            k_we    = 1'b1;
            k_waddr = r_clr;
            k_wdata = '0;
            s_we    = 1'b1;
            s_waddr = r_clr;
            s_wdata = SIZE_W'(1);
        end else if (i_cmd.link) begin
            // equal ranks: a's root absorbs b's root and grows, saturating
            k_we = (r_mode == MODE_RANK) && (r_ka == k_rdata) && (r_ka != RANK_MAX);
            s_we = (r_mode == MODE_SIZE);
        end
    end

    ufe_ram #(.WIDTH(AW), .DEPTH(NODES)) u_parent (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    ufe_ram #(.WIDTH(RANK_W), .DEPTH(NODES)) u_rank (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_raddr (k_addr),
        .o_rdata (k_rdata)
    );

    ufe_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_size (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (k_addr),
        .o_rdata (s_rdata)
    );

    always_comb begin
        o_sts             = '0;
        o_sts.in_ok       = a_ok && (i_op == OP_FIND || b_ok);
        o_sts.op          = r_op;
        o_sts.side        = r_side;
        o_sts.at_root     = (p_rdata == r_cur);
        o_sts.cur_is_root = (r_cur == r_root);
        o_sts.comp_end    = (p_rdata == r_root);
        o_sts.roots_eq    = (r_root_a == r_root);
        o_sts.clr_last    = (r_clr == AW'(NODES - 1));
    end

    assign o_root   = r_out_root;
    assign o_merged = r_out_merged;

    `UFE_ASSERT_IMP(a_link_distinct, i_cmd.link, r_root_a != r_root, "linking a root to itself")
    `UFE_ASSERT_IMP(a_comp_not_root, i_cmd.comp_step, r_cur != r_root, "compressing the root")
    `UFE_ASSERT_IMP(a_merge_union, i_cmd.out_load && r_merged, r_op == OP_UNION,
        "merge flagged on find")

endmodule

[test/union_find_engine_checker.sv]
`timescale 1ns / 100ps

module union_find_engine_checker
    import ufe_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  logic          i_op,
    input  logic [NW-1:0] i_node_a,
    input  logic [NW-1:0] i_node_b,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  logic [NW-1:0] i_root,
    input  logic          i_merged,
    output int            o_fail_count,
    output int            o_results_owed
);

    typedef struct packed {
        logic [NW-1:0] root;
        logic          merged;
    } t_root_reply;

    logic [NW-1:0]     parent_of [NODES];
    logic [RANK_W-1:0] rank_of   [NODES];
    logic [SIZE_W-1:0] size_of   [NODES];
    logic              link_mode;
    t_root_reply       replies_owed [$];
    t_root_reply       oldest;
    int                replies_seen;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $realtime, replies_seen, what, got, want);
        o_fail_count++;
    endtask

    // Walk to the root, then point every node on the path straight at it.
    function automatic logic [NW-1:0] find_and_flatten(input logic [NW-1:0] node);
        logic [NW-1:0] top;
        logic [NW-1:0] walk;
        logic [NW-1:0] nxt;
        top = node;
        while (parent_of[top] != top)
            top = parent_of[top];
        walk = node;
        while (walk != top) begin
            nxt             = parent_of[walk];
            parent_of[walk] = top;
            walk            = nxt;
        end
        return top;
    endfunction

    function automatic t_root_reply resolve_item(input logic op, input logic [NW-1:0] a,
                                                 input logic [NW-1:0] b);
        logic [NW-1:0] ra;
        logic [NW-1:0] rb;
        logic [SIZE_W:0] total;
        t_root_reply reply;
        reply.root   = a;
        reply.merged = 1'b0;
        if (int'(a) >= NODES || (op == OP_UNION && int'(b) >= NODES))
            return reply;
        ra         = find_and_flatten(a);
        reply.root = ra;
        if (op == OP_UNION) begin
            rb = find_and_flatten(b);
            if (ra != rb) begin
                reply.merged = 1'b1;
                if (link_mode == MODE_RANK) begin
                    if (rank_of[ra] >= rank_of[rb]) begin
                        // tie grows a's rank, saturating
                        if (rank_of[ra] == rank_of[rb] && rank_of[ra] != RANK_MAX)
                            rank_of[ra] = rank_of[ra] + 1'b1;
                        parent_of[rb] = ra;
                    end else begin
                        parent_of[ra] = rb;
                        reply.root    = rb;
                    end
                end else begin
                    total = {1'b0, size_of[ra]} + {1'b0, size_of[rb]};
                    if (total > {1'b0, SIZE_MAX})
                        total = {1'b0, SIZE_MAX};
                    if (size_of[ra] > size_of[rb]) begin
                        parent_of[rb] = ra;
                        size_of[ra]   = total[SIZE_W-1:0];
                    end else begin
                        // tie goes to b's root
                        parent_of[ra] = rb;
                        size_of[rb]   = total[SIZE_W-1:0];
                        reply.root    = rb;
                    end
                end
            end
        end
        return reply;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NODES; n++) begin
                parent_of[n] = NW'(n);
                rank_of[n]   = '0;
                size_of[n]   = SIZE_W'(1);
            end
            link_mode = MODE_RANK;
            replies_owed.delete();
            replies_seen = 0;
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                replies_seen++;
                if (replies_owed.size() == 0) begin
                    report_mismatch("root with no transfer outstanding", 32'(i_root), 32'd0);
                end else begin
                    oldest = replies_owed.pop_front();
                    if (i_root !== oldest.root)
                        report_mismatch("root", 32'(i_root), 32'(oldest.root));
                    if (i_merged !== oldest.merged)
                        report_mismatch("merged", 32'(i_merged), 32'(oldest.merged));
                end
            end
            if (i_cfg_wr_en)
                link_mode = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                replies_owed.insert(replies_owed.size(),
                                    resolve_item(i_op, i_node_a, i_node_b));
        end
        o_results_owed <= replies_owed.size();
    end

endmodule

[test/union_find_engine_test.sv]
`timescale 1ns / 100ps

module union_find_engine_test;
    import ufe_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_AT     = 5000;
    localparam int HOLD_LEN    = 600;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_wr_en;
    logic          i_cfg_wr_data;
    logic          i_valid;
    logic          o_stall;
    logic          i_op;
    logic [NW-1:0] i_node_a;
    logic [NW-1:0] i_node_b;
    logic          o_valid;
    logic          i_stall;
    logic [NW-1:0] o_root;
    logic          o_merged;
    int            fail_count;
    int            results_owed;
    int            free_run;

    union_find_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_node_a      (i_node_a),
        .i_node_b      (i_node_b),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_root        (o_root),
        .o_merged      (o_merged)
    );

    union_find_engine_checker uf_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_op           (i_op),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_root         (o_root),
        .i_merged       (o_merged),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Ends the run when no transfer happens on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Result side backpressure: free runs, random stalls, long stalls, one long hold-off.
    initial begin : result_side
        int cyc;
        int run;
        int pct;
        int kind;
        logic held;
        i_stall = 1'b0;
        cyc     = 0;
        held    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            kind = $urandom_range(0, 9);
            run  = $urandom_range(1, 40);
            if (kind < 4) begin
                pct = 0;
            end else if (kind < 7) begin
                pct = 50;
            end else if (kind < 9) begin
                pct = 25;
            end else begin
                pct = 100;
                run = $urandom_range(15, 80);
            end
            if (!held && cyc >= HOLD_AT) begin
                held = 1'b1;
                pct  = 100;
                run  = HOLD_LEN;
            end
            repeat (run) begin
                @(negedge i_clk);
                cyc++;
                i_stall = ($urandom_range(0, 99) < pct);
            end
        end
    end

    task automatic send_item(input logic op, input logic [NW-1:0] a, input logic [NW-1:0] b);
        int gap;
        int roll;
        gap = 0;
        if (free_run > 0) begin
            free_run--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                free_run = $urandom_range(10, 40);
            else if (roll < 55)
                gap = 0;
            else if (roll < 88)
                gap = $urandom_range(1, 3);
            else if (roll < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_op     = op;
        i_node_a = a;
        i_node_b = b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Every item returns a result, so an empty queue means the engine is idle.
    task automatic drain();
        i_valid = 1'b0;
        while (results_owed != 0) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = mode;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic mix_operations(input int count, input int base, input int span);
        logic op;
        logic [NW-1:0] a;
        logic [NW-1:0] b;
        for (int k = 0; k < count; k++) begin
            op = ($urandom_range(0, 99) < 55) ? OP_UNION : OP_FIND;
            if ($urandom_range(0, 9) == 0) begin
                a = NW'($urandom_range(0, NODES_DEF - 1));
                b = NW'($urandom_range(0, NODES_DEF - 1));
            end else begin
                a = NW'((base + $urandom_range(0, span - 1)) % NODES_DEF);
                b = NW'((base + $urandom_range(0, span - 1)) % NODES_DEF);
            end
            if ($urandom_range(0, 19) == 0)
                b = a;
            send_item(op, a, b);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_valid       = 1'b0;
        i_op          = OP_FIND;
        i_node_a      = '0;
        i_node_b      = '0;
        free_run      = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // engine clears its tables before taking input
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);

        write_mode(MODE_RANK);
        send_item(OP_FIND,  10'd0,   10'd1023);
        send_item(OP_FIND,  10'd1023, 10'd0);
        send_item(OP_UNION, 10'd0,   10'd1023);   // equal ranks
        send_item(OP_UNION, 10'd1023, 10'd0);     // already joined
        send_item(OP_UNION, 10'd682, 10'd682);    // self union
        send_item(OP_UNION, 10'd341, 10'd682);
        send_item(OP_UNION, 10'd1,   10'd341);    // lower rank under higher
        send_item(OP_UNION, 10'd2,   10'd3);
        send_item(OP_UNION, 10'd341, 10'd2);      // equal ranks of 1
        send_item(OP_UNION, 10'd0,   10'd3);
        send_item(OP_FIND,  10'd1023, 10'd682);   // path of depth two gets flattened
        send_item(OP_FIND,  10'd3,   10'd1023);
        drain();

        write_mode(MODE_SIZE);
        send_item(OP_UNION, 10'd10,  10'd11);     // size tie, b's root wins
        send_item(OP_UNION, 10'd12,  10'd11);
        send_item(OP_UNION, 10'd11,  10'd13);     // larger set on a's side
        send_item(OP_UNION, 10'd10,  10'd341);
        send_item(OP_UNION, 10'd20,  10'd21);
        send_item(OP_UNION, 10'd22,  10'd23);
        send_item(OP_UNION, 10'd20,  10'd22);
        send_item(OP_FIND,  10'd20,  10'd0);
        send_item(OP_UNION, 10'd1023, 10'd20);
        send_item(OP_UNION, 10'd12,  10'd682);
        drain();

        write_mode(MODE_SIZE);
        mix_operations(360, 0, 256);
        drain();
        write_mode(MODE_RANK);
        mix_operations(360, 256, 256);
        drain();
        write_mode(MODE_SIZE);
        mix_operations(360, 512, 512);
        drain();
        write_mode(MODE_RANK);
        mix_operations(350, 0, 1024);
        drain();
        repeat (60) @(negedge i_clk);

        if (fail_count == 0 && results_owed == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
